// ===== rtl/yuvsol_pkg.sv =====
// ----------------------------------------------------------------------------
// yuvsol_pkg
// Shared constants and types for the YUV 4:2:0 solarize pixel block.
// ----------------------------------------------------------------------------
package yuvsol_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_WIDTH_EVEN = (MAX_WIDTH / 2) * 2;
   localparam int BANK_DEPTH     = MAX_WIDTH_EVEN / 2;
   localparam int BANK_AW        = (BANK_DEPTH > 2) ? $clog2(BANK_DEPTH) : 1;
   localparam int COL_W          = BANK_AW + 1;
   localparam int LW_W           = 11;
   localparam int CMP_W          = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LW_W;

   localparam int Q16_W = 27;

   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD    = 2'd0,
      CSR_INVERT_BELOW = 2'd1,
      CSR_LINE_WIDTH   = 2'd2
   } csr_reg_type;

   localparam logic [7:0]       THRESHOLD_RST  = 8'd128;
   localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 11'd440;

   // YUV to RGB, Q16
   localparam logic signed [17:0] K_RV = 18'sd89831;
   localparam logic signed [17:0] K_GV = 18'sd45744;
   localparam logic signed [17:0] K_GU = 18'sd22127;
   localparam logic signed [17:0] K_BU = 18'sd113538;

   // RGB to YUV, BT.601 integer form
   localparam logic signed [8:0] C_YR = 9'sd66;
   localparam logic signed [8:0] C_YG = 9'sd129;
   localparam logic signed [8:0] C_YB = 9'sd25;
   localparam logic signed [8:0] C_UR = 9'sd38;
   localparam logic signed [8:0] C_UG = 9'sd74;
   localparam logic signed [8:0] C_UB = 9'sd112;
   localparam logic signed [8:0] C_VR = 9'sd112;
   localparam logic signed [8:0] C_VG = 9'sd94;
   localparam logic signed [8:0] C_VB = 9'sd18;

endpackage

// ===== rtl/yuvsol_req_if.sv =====
// ----------------------------------------------------------------------------
// yuvsol_req_if
// Pixel input channel: valid/ready handshake with one pixel per beat.
// ----------------------------------------------------------------------------
interface yuvsol_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_in;
   logic [7:0] cb_in;
   logic [7:0] cr_in;
   logic       frame_start;

   modport source (output valid, output luma_in, output cb_in, output cr_in,
                   output frame_start, input ready);
   modport sink   (input valid, input luma_in, input cb_in, input cr_in,
                   input frame_start, output ready);
endinterface

// ===== rtl/yuvsol_rsp_if.sv =====
// ----------------------------------------------------------------------------
// yuvsol_rsp_if
// Pixel result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface yuvsol_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_out;
   logic       chroma_valid;
   logic [7:0] cb_out;
   logic [7:0] cr_out;

   modport source (output valid, output luma_out, output chroma_valid,
                   output cb_out, output cr_out, input ready);
   modport sink   (input valid, input luma_out, input chroma_valid,
                   input cb_out, input cr_out, output ready);
endinterface

// ===== rtl/yuv420_solarize_pixel.sv =====
// Throughput: one pixel per cycle until back-pressure fills every stage; five
// pipeline stages with per-stage stall, so an input beat is taken whenever
// any stage holds a bubble or the result channel is ready.
// Reset (synchronous, active high) clears the pipeline valids, column and row
// state, left chroma and config registers; the line buffers are not cleared.
// ----------------------------------------------------------------------------
// yuv420_solarize_pixel
// YUV to RGB, per-channel solarize, back to YUV; 2x2 chroma averaging using
// even/odd column banks of the previous row.
// ----------------------------------------------------------------------------
module yuv420_solarize_pixel (
   input  logic                      clock,
   input  logic                      reset,
   yuvsol_req_if.sink                req_ch,
   yuvsol_rsp_if.source              rsp_ch,
   input  logic                      csr_we,
   input  yuvsol_pkg::csr_index_type csr_index,
   input  yuvsol_pkg::csr_data_type  csr_wdata
);
   import yuvsol_pkg::*;

   // config
   logic [7:0]      threshold_ff;
   logic            invert_below_ff;
   logic [LW_W-1:0] line_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RST;
         invert_below_ff <= 1'b0;
         line_width_ff   <= LINE_WIDTH_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_THRESHOLD)    threshold_ff    <= csr_wdata[7:0];
         if (csr_index == CSR_INVERT_BELOW) invert_below_ff <= csr_wdata[0];
         if (csr_index == CSR_LINE_WIDTH)   line_width_ff   <= csr_wdata;
      end
   end

   // stage enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || rsp_ch.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ch.ready = en1;

   logic accept;
   assign accept = req_ch.valid && en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_ch.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // column / row tracking
   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic             row_odd_ff, row_odd_in;
   logic [COL_W-1:0] col_cur;
   logic             odd_cur;
   logic [CMP_W-1:0] eff_width;
   logic [CMP_W-1:0] col_plus;

   always_comb begin
      eff_width = CMP_W'(line_width_ff) & ~CMP_W'(1);
      if (eff_width < CMP_W'(2)) begin
         eff_width = CMP_W'(2);
      end else if (eff_width > CMP_W'(MAX_WIDTH_EVEN)) begin
         eff_width = CMP_W'(MAX_WIDTH_EVEN);
      end
      col_cur = req_ch.frame_start ? '0 : column_count_ff;
      odd_cur = req_ch.frame_start ? 1'b0 : row_odd_ff;
      col_plus = CMP_W'(col_cur) + CMP_W'(1);
      if (col_plus >= eff_width) begin
         column_count_in = '0;
         row_odd_in      = !odd_cur;
      end else begin
         column_count_in = col_plus[COL_W-1:0];
         row_odd_in      = odd_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_odd_ff      <= 1'b0;
      end else if (accept) begin
         column_count_ff <= column_count_in;
         row_odd_ff      <= row_odd_in;
      end
   end

   // stage 1: input register
   logic [7:0]       y1_ff, u1_ff, vv1_ff;
   logic [COL_W-1:0] col1_ff, col2_ff, col3_ff, col4_ff;
   logic             odd1_ff, odd2_ff, odd3_ff, odd4_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         y1_ff   <= req_ch.luma_in;
         u1_ff   <= req_ch.cb_in;
         vv1_ff  <= req_ch.cr_in;
         col1_ff <= col_cur;
         odd1_ff <= odd_cur;
      end
   end

   // stage 2: Q16 sums
   logic signed [8:0]       du1, dv1;
   logic signed [Q16_W-1:0] yq1, p_rv, p_gv, p_gu, p_bu;
   logic signed [Q16_W-1:0] rq2_ff, gq2_ff, bq2_ff;

   always_comb begin
      du1  = $signed({1'b0, u1_ff}) - 9'sd128;
      dv1  = $signed({1'b0, vv1_ff}) - 9'sd128;
      yq1  = $signed({{(Q16_W-24){1'b0}}, y1_ff, 16'b0});
      p_rv = K_RV * dv1;
      p_gv = K_GV * dv1;
      p_gu = K_GU * du1;
      p_bu = K_BU * du1;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         rq2_ff  <= yq1 + p_rv;
         gq2_ff  <= yq1 - p_gv - p_gu;
         bq2_ff  <= yq1 + p_bu;
         col2_ff <= col1_ff;
         odd2_ff <= odd1_ff;
      end
   end

   // stage 3: clamp and solarize
   function automatic logic [7:0] q16_pix(input logic signed [Q16_W-1:0] s);
      logic [Q16_W-18:0] v;
      logic [7:0]        p;
      v = s[Q16_W-2:16];
      if (s[Q16_W-1]) begin
         p = 8'd0;
      end else if (v > (Q16_W-17)'(255)) begin
         p = 8'd255;
      end else begin
         p = v[7:0];
      end
      return p;
   endfunction

   function automatic logic [7:0] solarize(input logic [7:0] c, input logic [7:0] th,
                                           input logic below);
      logic [7:0] o;
      o = c;
      if (below) begin
         if (c < th) o = 8'd255 - c;
      end else begin
         if (c > th) o = 8'd255 - c;
      end
      return o;
   endfunction

   logic [7:0] r3_ff, g3_ff, b3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         r3_ff   <= solarize(q16_pix(rq2_ff), threshold_ff, invert_below_ff);
         g3_ff   <= solarize(q16_pix(gq2_ff), threshold_ff, invert_below_ff);
         b3_ff   <= solarize(q16_pix(bq2_ff), threshold_ff, invert_below_ff);
         col3_ff <= col2_ff;
         odd3_ff <= odd2_ff;
      end
   end

   // stage 4: back to YUV, line buffer read
   logic signed [17:0] rs3, gs3, bs3, ysum3, usum3, vsum3;
   logic [7:0]         y4_ff, u4_ff, v4d_ff;

   always_comb begin
      rs3   = $signed({10'b0, r3_ff});
      gs3   = $signed({10'b0, g3_ff});
      bs3   = $signed({10'b0, b3_ff});
      ysum3 = C_YR * rs3 + C_YG * gs3 + C_YB * bs3 + 18'sd128;
      usum3 = C_UB * bs3 - C_UR * rs3 - C_UG * gs3 + 18'sd32896;
      vsum3 = C_VR * rs3 - C_VG * gs3 - C_VB * bs3 + 18'sd32896;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         y4_ff   <= ysum3[15:8] + 8'd16;
         u4_ff   <= usum3[15:8];
         v4d_ff  <= vsum3[15:8];
         col4_ff <= col3_ff;
         odd4_ff <= odd3_ff;
      end
   end

   // previous-row chroma, split into even and odd column banks
   logic [7:0] cb_even_mem [BANK_DEPTH];
   logic [7:0] cb_odd_mem  [BANK_DEPTH];
   logic [7:0] cr_even_mem [BANK_DEPTH];
   logic [7:0] cr_odd_mem  [BANK_DEPTH];
   logic [7:0] cb_even_ff, cb_odd_ff, cr_even_ff, cr_odd_ff;
   logic       line_wr;

   assign line_wr = en5 && v4_ff && !odd4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         cb_even_ff <= cb_even_mem[col3_ff[BANK_AW:1]];
         cb_odd_ff  <= cb_odd_mem[col3_ff[BANK_AW:1]];
         cr_even_ff <= cr_even_mem[col3_ff[BANK_AW:1]];
         cr_odd_ff  <= cr_odd_mem[col3_ff[BANK_AW:1]];
      end
      if (line_wr) begin
         if (col4_ff[0]) begin
            cb_odd_mem[col4_ff[BANK_AW:1]] <= u4_ff;
            cr_odd_mem[col4_ff[BANK_AW:1]] <= v4d_ff;
         end else begin
            cb_even_mem[col4_ff[BANK_AW:1]] <= u4_ff;
            cr_even_mem[col4_ff[BANK_AW:1]] <= v4d_ff;
         end
      end
   end

   // chroma of the previous pixel
   logic [7:0] cb_left_ff, cr_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_left_ff <= 8'd0;
         cr_left_ff <= 8'd0;
      end else if (en5 && v4_ff) begin
         cb_left_ff <= u4_ff;
         cr_left_ff <= v4d_ff;
      end
   end

   // stage 5: 2x2 average and result register
   logic [9:0] su4, sv4;
   logic       blk4;
   logic [7:0] luma5_ff, cb5_ff, cr5_ff;
   logic       cv5_ff;

   always_comb begin
      su4  = {2'b0, cb_even_ff} + {2'b0, cb_odd_ff} + {2'b0, cb_left_ff} + {2'b0, u4_ff};
      sv4  = {2'b0, cr_even_ff} + {2'b0, cr_odd_ff} + {2'b0, cr_left_ff} + {2'b0, v4d_ff};
      blk4 = odd4_ff && col4_ff[0];
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         luma5_ff <= y4_ff;
         cv5_ff   <= blk4;
         cb5_ff   <= blk4 ? su4[9:2] : 8'd0;
         cr5_ff   <= blk4 ? sv4[9:2] : 8'd0;
      end
   end

   assign rsp_ch.valid        = v5_ff;
   assign rsp_ch.luma_out     = luma5_ff;
   assign rsp_ch.chroma_valid = cv5_ff;
   assign rsp_ch.cb_out       = cb5_ff;
   assign rsp_ch.cr_out       = cr5_ff;

endmodule

// ===== tb/sv/yuv420_solarize_pixel_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_solarize_pixel_test
// Self-checking bench for the YUV 4:2:0 solarize pixel block. A behavioral
// copy of the pixel path (Q16 YUV to RGB, solarize, back to YUV, 2x2 chroma
// averaging over a shadow line buffer) predicts every result beat. A queue
// of pixels feeds a clocked driver with random gaps; under random
// back-pressure, a clocked monitor compares each result beat against the oldest
// prediction. Register settings change between drained phases, covering
// threshold and width extremes, odd and out-of-range widths, rows cut short
// by a narrower width, and frame restarts mid-row.
// ----------------------------------------------------------------------------
module yuv420_solarize_pixel_test;
   import yuvsol_pkg::*;

   localparam int Q_RV          = 89831;
   localparam int Q_GV          = 45744;
   localparam int Q_GU          = 22127;
   localparam int Q_BU          = 113538;
   localparam int RANDOM_PIXELS = 1300;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       fs;
   } pixel_beat_type;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] cb;
      logic [7:0] cr;
   } yuv_result_type;

   typedef struct packed {
      pixel_beat_type pix;
      yuv_result_type res;
   } pixel_job_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   yuvsol_req_if req_if ();
   yuvsol_rsp_if rsp_if ();

   yuv420_solarize_pixel u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // shadow of the block state and registers
   logic [7:0]  line_cb [MAX_WIDTH_EVEN];
   logic [7:0]  line_cr [MAX_WIDTH_EVEN];
   bit          line_written [MAX_WIDTH_EVEN];
   logic [7:0]  left_cb = '0;
   logic [7:0]  left_cr = '0;
   int          col_pos = 0;
   bit          row_odd = 1'b0;
   logic [7:0]  sol_threshold = THRESHOLD_RST;
   bit          sol_invert = 1'b0;
   logic [10:0] sol_width = LINE_WIDTH_RST;

   pixel_job_type  pixel_backlog [$];
   yuv_result_type due_results [$];
   pixel_job_type  cur_job;

   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   int send_wait = 0;
   int rsp_stall = 0;
   int gap_max = 0;
   int stall_max = 0;
   int errors = 0;
   int n_results = 0;
   int n_chroma = 0;
   int n_writes = 0;
   int n_phases = 0;

   function automatic int to_pixel(int s);
      int v;
      if (s < 0) return 0;
      v = s >>> 16;
      return (v > 255) ? 255 : v;
   endfunction

   function automatic int solarize(int c);
      if (sol_invert) begin
         if (c < sol_threshold) return 255 - c;
      end else begin
         if (c > sol_threshold) return 255 - c;
      end
      return c;
   endfunction

   function automatic int eff_width();
      int w;
      w = sol_width & ~1;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH_EVEN) w = MAX_WIDTH_EVEN;
      return w;
   endfunction

   // an odd-row, odd-column pixel reads two line entries; both must exist
   function automatic bit needs_restart();
      if (!row_odd || !col_pos[0]) return 1'b0;
      return !(line_written[col_pos-1] && line_written[col_pos]);
   endfunction

   function automatic yuv_result_type solarize_pixel(pixel_beat_type p);
      yuv_result_type r;
      int y, du, dv, rr, gg, bb, yo, uo, vo, su, sv, pos;
      y  = p.luma;
      du = int'(p.cb) - 128;
      dv = int'(p.cr) - 128;
      if (p.fs) begin
         col_pos = 0;
         row_odd = 1'b0;
      end
      pos = col_pos;
      rr = solarize(to_pixel(y * 65536 + Q_RV * dv));
      gg = solarize(to_pixel(y * 65536 - Q_GV * dv - Q_GU * du));
      bb = solarize(to_pixel(y * 65536 + Q_BU * du));
      yo = ((66 * rr + 129 * gg + 25 * bb + 128) >>> 8) + 16;
      uo = (-38 * rr - 74 * gg + 112 * bb + 128 + 32768) >>> 8;
      vo = (112 * rr - 94 * gg - 18 * bb + 128 + 32768) >>> 8;
      r = '0;
      r.luma = yo[7:0];
      if (!row_odd) begin
         line_cb[pos] = uo[7:0];
         line_cr[pos] = vo[7:0];
         line_written[pos] = 1'b1;
      end else if (pos[0]) begin
         su = int'(line_cb[pos-1]) + int'(line_cb[pos]) + int'(left_cb) + uo;
         sv = int'(line_cr[pos-1]) + int'(line_cr[pos]) + int'(left_cr) + vo;
         r.chroma_valid = 1'b1;
         r.cb = su[9:2];
         r.cr = sv[9:2];
      end
      left_cb = uo[7:0];
      left_cr = vo[7:0];
      if (pos + 1 >= eff_width()) begin
         col_pos = 0;
         row_odd = ~row_odd;
      end else begin
         col_pos = pos + 1;
      end
      return r;
   endfunction

   task automatic queue_pixel(int y, int u, int v, bit fs);
      pixel_job_type j;
      j.pix.luma = y[7:0];
      j.pix.cb   = u[7:0];
      j.pix.cr   = v[7:0];
      j.pix.fs   = fs | needs_restart();
      j.res      = solarize_pixel(j.pix);
      pixel_backlog.push_back(j);
   endtask

   task automatic write_reg(csr_reg_type idx, int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[10:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_THRESHOLD:    sol_threshold = value[7:0];
         CSR_INVERT_BELOW: sol_invert = value[0];
         CSR_LINE_WIDTH:   sol_width = value[10:0];
         default:          ;
      endcase
      n_writes++;
   endtask

   task automatic settle();
      while (pixel_backlog.size() != 0 || req_if.valid || due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_sample();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic int pick_idle();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 2;
         default: return 11;
      endcase
   endfunction

   function automatic int pick_width();
      int k;
      k = $urandom_range(0, 9);
      if (k < 4) return 2 * $urandom_range(1, 4);
      if (k < 7) return $urandom_range(2, 40);
      if (k < 9) begin
         case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 3;
            3:       return 1023;
            4:       return 1025;
            default: return 2047;
         endcase
      end
      return $urandom_range(100, 1024);
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset && (!req_if.valid || req_fire)) begin
         if (send_wait > 0 || pixel_backlog.size() == 0) begin
            req_if.valid <= 1'b0;
            if (send_wait > 0) send_wait--;
         end else begin
            cur_job = pixel_backlog.pop_front();
            req_if.valid       <= 1'b1;
            req_if.luma_in     <= cur_job.pix.luma;
            req_if.cb_in       <= cur_job.pix.cb;
            req_if.cr_in       <= cur_job.pix.cr;
            req_if.frame_start <= cur_job.pix.fs;
            send_wait = $urandom_range(0, gap_max);
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) rsp_stall = $urandom_range(0, stall_max);
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      yuv_result_type want;
      req_fire = !reset && req_if.valid && req_if.ready;
      rsp_fire = !reset && rsp_if.valid && rsp_if.ready;
      if (req_fire) due_results.push_back(cur_job.res);
      if (rsp_fire) begin
         if (due_results.size() == 0) begin
            $error("result beat with nothing expected: luma_out %0d", rsp_if.luma_out);
            errors++;
         end else begin
            want = due_results.pop_front();
            n_results++;
            if (want.chroma_valid) n_chroma++;
            if (rsp_if.luma_out !== want.luma) begin
               $error("luma_out: expected %0d, got %0d", want.luma, rsp_if.luma_out);
               errors++;
            end
            if (rsp_if.chroma_valid !== want.chroma_valid) begin
               $error("chroma_valid: expected %0d, got %0d", want.chroma_valid,
                      rsp_if.chroma_valid);
               errors++;
            end
            if (rsp_if.cb_out !== want.cb) begin
               $error("cb_out: expected %0d, got %0d", want.cb, rsp_if.cb_out);
               errors++;
            end
            if (rsp_if.cr_out !== want.cr) begin
               $error("cr_out: expected %0d, got %0d", want.cr, rsp_if.cr_out);
               errors++;
            end
         end
      end
   end

   initial begin
      #1000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int n_random, len, frame_left;
      bit fs;
      n_random   = 0;
      frame_left = 0;
      req_if.valid       = 1'b0;
      req_if.luma_in     = '0;
      req_if.cb_in       = '0;
      req_if.cr_in       = '0;
      req_if.frame_start = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_we    = 1'b0;
      csr_index = CSR_THRESHOLD;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset defaults
      gap_max   = 3;
      stall_max = 3;
      queue_pixel(0, 0, 0, 1);
      queue_pixel(255, 255, 255, 0);
      queue_pixel(255, 0, 255, 0);
      queue_pixel(0, 255, 0, 0);
      settle();

      // 4-wide frame with extreme chroma, then a restart mid-row
      write_reg(CSR_LINE_WIDTH, 4);
      write_reg(CSR_THRESHOLD, 128);
      write_reg(CSR_INVERT_BELOW, 0);
      queue_pixel(0, 0, 0, 1);
      queue_pixel(255, 255, 255, 0);
      queue_pixel(255, 0, 0, 0);
      queue_pixel(0, 255, 255, 0);
      queue_pixel(128, 128, 128, 0);
      queue_pixel(255, 0, 255, 0);
      queue_pixel(0, 255, 0, 0);
      queue_pixel(16, 128, 128, 0);
      queue_pixel(50, 60, 70, 0);
      queue_pixel(90, 200, 30, 1);
      settle();

      // odd width rounds down to 6; phase stops mid odd row
      write_reg(CSR_THRESHOLD, 0);
      write_reg(CSR_INVERT_BELOW, 1);
      write_reg(CSR_LINE_WIDTH, 7);
      queue_pixel(255, 255, 0, 0);
      queue_pixel(0, 0, 255, 0);
      queue_pixel(235, 16, 240, 0);
      queue_pixel(16, 240, 16, 0);
      queue_pixel(128, 0, 0, 0);
      queue_pixel(200, 255, 255, 0);
      queue_pixel(1, 254, 2, 0);
      queue_pixel(254, 1, 253, 0);
      settle();

      // width 1 saturates to 2 and cuts the current row short
      write_reg(CSR_THRESHOLD, 255);
      write_reg(CSR_INVERT_BELOW, 0);
      write_reg(CSR_LINE_WIDTH, 1);
      queue_pixel(255, 128, 0, 0);
      queue_pixel(0, 128, 255, 0);
      queue_pixel(255, 255, 255, 0);
      queue_pixel(0, 0, 0, 0);
      settle();

      while (n_random < RANDOM_PIXELS) begin
         n_phases++;
         gap_max   = pick_idle();
         stall_max = pick_idle();
         if (n_phases == 1) write_reg(CSR_LINE_WIDTH, 2047);
         else if (n_phases == 2) write_reg(CSR_LINE_WIDTH, 1024);
         else if ($urandom_range(0, 4) != 0) write_reg(CSR_LINE_WIDTH, pick_width());
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
               0:       write_reg(CSR_THRESHOLD, 0);
               1:       write_reg(CSR_THRESHOLD, 255);
               default: write_reg(CSR_THRESHOLD, $urandom_range(0, 255));
            endcase
         end
         if ($urandom_range(0, 1)) write_reg(CSR_INVERT_BELOW, $urandom_range(0, 1));
         if ($urandom_range(0, 1)) frame_left = 0;
         len = (n_phases <= 2) ? 40 : $urandom_range(20, 80);
         for (int i = 0; i < len; i++) begin
            fs = (frame_left == 0) || ($urandom_range(0, 49) == 0);
            if (fs) begin
               frame_left = 2 * eff_width() * $urandom_range(1, 3);
               if (frame_left > 300) frame_left = 300;
            end
            frame_left--;
            queue_pixel(pick_sample(), pick_sample(), pick_sample(), fs);
            n_random++;
         end
         settle();
      end

      $display("Checked %0d result beats (%0d with averaged chroma) over %0d phases,",
               n_results, n_chroma, n_phases + 4);
      $display("with %0d register writes across thresholds, modes and line widths.",
               n_writes);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/yuvsol_pkg.sv
rtl/yuvsol_req_if.sv
rtl/yuvsol_rsp_if.sv
rtl/yuv420_solarize_pixel.sv
tb/sv/yuv420_solarize_pixel_test.sv
